>>> rtl/core/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/fsvs_pkg.sv
// Package for the fair-share virtual run time scheduler.
// Holds types, codes, widths and the weight factor table; depends on nothing.
`default_nettype none
package fsvs_pkg;
   localparam int DEF_MAX_TASKS   = 64;
   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int ADDR_W   = 4;
   localparam int WEIGHT_W = 23;
   localparam int VRUN_W   = 56;
   localparam int SUM_W    = 40;
   localparam int DIV_W    = 49;
   localparam logic [VRUN_W-1:0] VRUN_MAX = '1;

   localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
   localparam logic [1:0] CMD_COMPLETE = 2'd1;
   localparam logic [1:0] CMD_PICK     = 2'd2;

   localparam logic [1:0] ST_ACCEPTED   = 2'd0;
   localparam logic [1:0] ST_DISPATCHED = 2'd1;
   localparam logic [1:0] ST_EMPTY      = 2'd2;
   localparam logic [1:0] ST_FULL       = 2'd3;

   localparam logic [1:0] REG_TARGET = 2'd0;
   localparam logic [1:0] REG_GRAN   = 2'd1;
   localparam logic [1:0] REG_BASE   = 2'd2;

   typedef struct packed {
      logic                valid;
      logic [5:0]          task_id;
      logic [VRUN_W-1:0]   vrun;
      logic [WEIGHT_W-1:0] weight;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctl_type;

   function automatic logic [14:0] factor_q8(input logic [5:0] idx);
      logic [14:0] f;
      case (idx)
         6'd0: f = 15'd22204;  6'd1: f = 15'd17764;  6'd2: f = 15'd14211;
         6'd3: f = 15'd11369;  6'd4: f = 15'd9095;   6'd5: f = 15'd7276;
         6'd6: f = 15'd5821;   6'd7: f = 15'd4657;   6'd8: f = 15'd3725;
         6'd9: f = 15'd2980;   6'd10: f = 15'd2384;  6'd11: f = 15'd1907;
         6'd12: f = 15'd1526;  6'd13: f = 15'd1221;  6'd14: f = 15'd977;
         6'd15: f = 15'd781;   6'd16: f = 15'd625;   6'd17: f = 15'd500;
         6'd18: f = 15'd400;   6'd19: f = 15'd320;   6'd20: f = 15'd256;
         6'd21: f = 15'd205;   6'd22: f = 15'd164;   6'd23: f = 15'd131;
         6'd24: f = 15'd105;   6'd25: f = 15'd84;    6'd26: f = 15'd67;
         6'd27: f = 15'd54;    6'd28: f = 15'd43;    6'd29: f = 15'd34;
         6'd30: f = 15'd27;    6'd31: f = 15'd22;    6'd32: f = 15'd18;
         6'd33: f = 15'd14;    6'd34: f = 15'd11;    6'd35: f = 15'd9;
         6'd36: f = 15'd7;     6'd37: f = 15'd6;     6'd38: f = 15'd5;
         6'd39: f = 15'd4;
         default: f = 15'd0;
      endcase
      return f;
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/fsvs_if.sv
// Request and response channel interfaces of the scheduler.
// Uses no package; payload widths are those of the channel fields.
`default_nettype none
interface fsvs_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic [5:0]        task_id;
   logic signed [7:0] nice;
   logic [19:0]       run_ms;
   modport source(output valid, command, task_id, nice, run_ms, input ready);
   modport sink(input valid, command, task_id, nice, run_ms, output ready);
endinterface

interface fsvs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  picked_id;
   logic [15:0] slice_ms;
   logic [6:0]  queue_depth;
   modport source(output valid, status, picked_id, slice_ms, queue_depth, input ready);
   modport sink(input valid, status, picked_id, slice_ms, queue_depth, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fair_share_vruntime_scheduler_core.sv
// Fair-share ready queue with virtual run time accounting.
// Depends on fsvs_pkg, fsvs_if, fsvs_cell, fsvs_div and assert_macros.svh.
//
// The req channel carries one command per transfer: enqueue, complete or pick.
// Every request produces exactly one transfer on the rsp channel.
// The queue is a row of cells kept sorted by virtual run time; an insert shifts
// cells from its place on, a pop all cells; the head is always the next pick.
// An enqueue with nonzero run time passes the charge, divide, insert and output
// states and a pick the pop, slice, divide and output states before its result
// loads in the rsp register; the divide states run the 49-step radix-2 divider.
// An enqueue with zero run time skips the divider; other requests go to output.
// A new request is taken once the previous result sits in the rsp register,
// so the block keeps working while the receiver stalls; a stalled rsp
// register holds its result until it is taken and then the next one loads.
// APB writes at byte addresses 0, 4 and 8 set the registers; pready is always high.
// The user writes them only while the block is idle; the block does not enforce it.
// Synchronous reset empties the queue, forgets every task and restores the
// register defaults. No clearing pass is needed after reset.
`default_nettype none
`include "assert_macros.svh"
module fair_share_vruntime_scheduler_core
   import fsvs_pkg::*;
#(
   parameter int MAX_TASKS   = DEF_MAX_TASKS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   fsvs_req_if.sink               req,
   fsvs_rsp_if.source             rsp,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   localparam int TASK_AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHARGE = 4'd1;
   localparam logic [3:0] S_DIVC   = 4'd2;
   localparam logic [3:0] S_INSERT = 4'd3;
   localparam logic [3:0] S_POP    = 4'd4;
   localparam logic [3:0] S_SLICE  = 4'd5;
   localparam logic [3:0] S_DIVS   = 4'd6;
   localparam logic [3:0] S_OUT    = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [23:0] target_ff, gran_ff;
   logic [15:0] base_ff;
   logic [23:0] t_eff, g_eff;
   logic [15:0] base_eff;

   logic [5:0] id_ff, tid_ff;
   logic [19:0] run_ff;
   logic [30:0] wprod_ff;
   logic [35:0] chg_ff;
   logic [46:0] tw_ff;
   logic [WEIGHT_W-1:0] w_ff, w_calc;
   logic [VRUN_W-1:0] vr_ff, mem_rd_ff, least_ff;
   logic [SUM_W-1:0] before_ff, sum_ff, s_eff;
   logic [CNT_W-1:0] count_ff;
   logic [MAX_TASKS-1:0] known_ff;
   logic [VRUN_W-1:0] vrun_mem [MAX_TASKS];

   logic [1:0] res_status_ff;
   logic [5:0] res_picked_ff;
   logic [15:0] res_slice_ff;
   logic [6:0] res_depth_ff;
   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [5:0] rsp_picked_ff;
   logic [15:0] rsp_slice_ff;
   logic [6:0] rsp_depth_ff;

   logic accept, req_id_ok, head_ok;
   logic [5:0] nice_idx;
   logic mem_we;
   logic [TASK_AW-1:0] mem_addr;
   logic div_start, div_busy, div_done;
   logic [DIV_W-1:0] div_num, div_den, div_q, slice_max;
   logic [56:0] vr_sum;
   logic [16:0] floor_ms;
   logic [15:0] slice_val;

   cell_ctl_type cell_ctl;
   entry_type new_entry, head;
   entry_type cell_q [QUEUE_DEPTH];
   entry_type left_e [QUEUE_DEPTH];
   entry_type right_e [QUEUE_DEPTH];
   logic before_q [QUEUE_DEPTH];
   logic lbef [QUEUE_DEPTH];

   assign t_eff = (target_ff < 24'd256) ? 24'd256 : target_ff;
   assign g_eff = (gran_ff < 24'd128) ? 24'd128 : gran_ff;
   assign base_eff = (base_ff == 16'd0) ? 16'd1 : base_ff;

   assign pready = 1'b1;
   always_comb begin
      case (paddr[3:2])
         REG_TARGET: prdata = {8'd0, target_ff};
         REG_GRAN:   prdata = {8'd0, gran_ff};
         REG_BASE:   prdata = {16'd0, base_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 24'd1536;
         gran_ff <= 24'd192;
         base_ff <= 16'd1024;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_TARGET: target_ff <= pwdata[23:0];
            REG_GRAN:   gran_ff <= pwdata[23:0];
            REG_BASE:   base_ff <= pwdata[15:0];
            default:    ;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign accept = req.valid && req.ready;
   assign req_id_ok = ({26'd0, req.task_id} < 32'(MAX_TASKS));
   assign nice_idx = (req.nice < -8'sd20) ? 6'd0 :
                     (req.nice > 8'sd19) ? 6'd39 : 6'(req.nice + 8'sd20);

   assign head = cell_q[0];
   assign head_ok = ({26'd0, head.task_id} < 32'(MAX_TASKS));
   assign w_calc = (wprod_ff[30:8] + {22'd0, wprod_ff[7]} == '0) ? WEIGHT_W'(1) :
                   WEIGHT_W'((32'(wprod_ff) + 32'd128) >> 8);
   assign new_entry = '{valid: 1'b1, task_id: id_ff, vrun: vr_ff, weight: w_ff};
   assign cell_ctl.insert = (state_ff == S_INSERT);
   assign cell_ctl.pop = (state_ff == S_POP);

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_e[i] = new_entry;
         assign lbef[i] = 1'b0;
      end else begin : g_mid
         assign left_e[i] = cell_q[i-1];
         assign lbef[i] = before_q[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_e[i] = '0;
      end else begin : g_inner
         assign right_e[i] = cell_q[i+1];
      end
      fsvs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .nw          (new_entry),
         .left        (left_e[i]),
         .left_before (lbef[i]),
         .right       (right_e[i]),
         .q           (cell_q[i]),
         .ahead       (before_q[i])
      );
   end

   assign s_eff = (before_ff == '0) ? SUM_W'(w_ff) : before_ff;
   always_comb begin
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      if (state_ff == S_CHARGE && run_ff != '0) begin
         div_start = 1'b1;
         div_num = DIV_W'({chg_ff, 8'd0}) + DIV_W'(w_calc >> 1);
         div_den = DIV_W'(w_calc);
      end else if (state_ff == S_SLICE) begin
         div_start = 1'b1;
         div_num = DIV_W'({tw_ff, 1'b0}) + DIV_W'({s_eff, 8'd0});
         div_den = DIV_W'({s_eff, 9'd0});
      end
   end

   fsvs_div #(.W(DIV_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_q)
   );

   assign vr_sum = {1'b0, vr_ff} + 57'(div_q);
   assign floor_ms = 17'((25'(g_eff) + 25'd128) >> 8);
   assign slice_max = (div_q > DIV_W'(floor_ms)) ? div_q : DIV_W'(floor_ms);
   assign slice_val = (slice_max == '0) ? 16'd1 :
                      (slice_max > DIV_W'(16'hFFFF)) ? 16'hFFFF : slice_max[15:0];

   always_comb begin
      mem_we = 1'b0;
      mem_addr = TASK_AW'(id_ff);
      if (state_ff == S_INSERT) begin
         mem_we = 1'b1;
      end else if (state_ff == S_POP && head_ok) begin
         mem_we = 1'b1;
         mem_addr = TASK_AW'(head.task_id);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vrun_mem[mem_addr] <= (state_ff == S_POP) ? head.vrun : vr_ff;
      end
      if (accept) begin
         mem_rd_ff <= vrun_mem[TASK_AW'(req.task_id)];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req.command == CMD_ENQUEUE && req_id_ok &&
                   count_ff < CNT_W'(QUEUE_DEPTH)) begin
                  state_in = S_CHARGE;
               end else if (req.command == CMD_PICK && count_ff != '0) begin
                  state_in = S_POP;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_CHARGE: state_in = (run_ff == '0) ? S_INSERT : S_DIVC;
         S_DIVC:   state_in = div_done ? S_INSERT : S_DIVC;
         S_INSERT: state_in = S_OUT;
         S_POP:    state_in = S_SLICE;
         S_SLICE:  state_in = S_DIVS;
         S_DIVS:   state_in = div_done ? S_OUT : S_DIVS;
         S_OUT:    state_in = (!rsp_valid_ff || rsp.ready) ? S_IDLE : S_OUT;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               id_ff <= req.task_id;
               run_ff <= req.run_ms;
               wprod_ff <= base_eff * factor_q8(nice_idx);
               chg_ff <= req.run_ms * base_eff;
               res_picked_ff <= '0;
               res_slice_ff <= '0;
               res_depth_ff <= 7'(count_ff);
               if (req.command == CMD_ENQUEUE && req_id_ok &&
                   count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                  res_status_ff <= ST_FULL;
               end else if (req.command == CMD_PICK && count_ff == '0) begin
                  res_status_ff <= ST_EMPTY;
               end else begin
                  res_status_ff <= ST_ACCEPTED;
               end
            end
         end
         S_CHARGE: begin
            w_ff <= w_calc;
            vr_ff <= known_ff[TASK_AW'(id_ff)] ? mem_rd_ff : least_ff;
         end
         S_DIVC: begin
            if (div_done) begin
               vr_ff <= vr_sum[56] ? VRUN_MAX : vr_sum[VRUN_W-1:0];
            end
         end
         S_INSERT: begin
            res_depth_ff <= 7'(count_ff + 1'b1);
         end
         S_POP: begin
            tid_ff <= head.task_id;
            w_ff <= head.weight;
            vr_ff <= head.vrun;
            before_ff <= sum_ff;
            tw_ff <= t_eff * head.weight;
            res_depth_ff <= 7'(count_ff - 1'b1);
         end
         S_DIVS: begin
            if (div_done) begin
               res_status_ff <= ST_DISPATCHED;
               res_picked_ff <= tid_ff;
               res_slice_ff <= slice_val;
            end
         end
         default: ;
      endcase
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp.ready)) begin
         rsp_status_ff <= res_status_ff;
         rsp_picked_ff <= res_picked_ff;
         rsp_slice_ff <= res_slice_ff;
         rsp_depth_ff <= res_depth_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         known_ff <= '0;
         count_ff <= '0;
         least_ff <= '0;
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && req.command == CMD_COMPLETE && req_id_ok) begin
            known_ff[TASK_AW'(req.task_id)] <= 1'b0;
         end
         if (state_ff == S_INSERT) begin
            known_ff[TASK_AW'(id_ff)] <= 1'b1;
            count_ff <= count_ff + 1'b1;
            sum_ff <= sum_ff + SUM_W'(w_ff);
            if (count_ff == '0 || vr_ff < least_ff) begin
               least_ff <= vr_ff;
            end
         end
         if (state_ff == S_POP) begin
            if (head_ok) begin
               known_ff[TASK_AW'(head.task_id)] <= 1'b1;
            end
            count_ff <= count_ff - 1'b1;
            sum_ff <= (sum_ff > SUM_W'(head.weight)) ? sum_ff - SUM_W'(head.weight) : '0;
            least_ff <= (count_ff == CNT_W'(1)) ? head.vrun : cell_q[1].vrun;
         end
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.picked_id = rsp_picked_ff;
   assign rsp.slice_ms = rsp_slice_ff;
   assign rsp.queue_depth = rsp_depth_ff;

   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_SAME(a_head_valid, clock, reset, 1'b1, (count_ff != '0) == cell_q[0].valid)
   `ASSERT_SAME(a_empty_sum, clock, reset, count_ff == '0, sum_ff == '0)
   `ASSERT_SAME(a_least_head, clock, reset, count_ff != '0, least_ff == cell_q[0].vrun)
   `ASSERT_NEXT(a_idle_div, clock, reset, state_ff == S_OUT, !div_busy)
endmodule
`default_nettype wire

>>> rtl/core/fsvs_cell.sv
// One cell of the sorted ready queue, holding a single entry.
// Depends on fsvs_pkg for the entry and control types.
`default_nettype none
module fsvs_cell
   import fsvs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire entry_type    nw,
   input  wire entry_type    left,
   input  wire logic         left_before,
   input  wire entry_type    right,
   output entry_type         q,
   output logic              ahead
);
   entry_type q_ff, q_in;

   assign ahead = !q_ff.valid || (nw.vrun < q_ff.vrun);
   assign q = q_ff;

   always_comb begin
      q_in = q_ff;
      if (ctl.insert && ahead) begin
         q_in = left_before ? left : nw;
      end else if (ctl.pop) begin
         q_in = right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/fsvs_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on fsvs_pkg only for the default width DIV_W.
`default_nettype none
module fsvs_div
   import fsvs_pkg::*;
#(
   parameter int W = DIV_W
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] num,
   input  wire logic [W-1:0] den,
   output logic              busy,
   output logic              done,
   output logic [W-1:0]      quo
);
   localparam int CNT_W = $clog2(W + 1);
   logic [W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [W:0] trial;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign busy = busy_ff;
   assign done = done_ff;
   assign quo = quo_ff;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire
